/* design/epda_pkg.sv */
package epda_pkg;

   // Fixed field and register widths.
   localparam int AVG_WIDTH     = 12;
   localparam int DIVISOR_WIDTH = 24;
   localparam int CSR_WIDTH     = 24;
   localparam int RSP_WIDTH     = 16;

   // Register indexes on the configuration port.
   localparam logic CSR_CYCLES_PER_MM = 1'b0;
   localparam logic CSR_MAX_DISTANCE  = 1'b1;

   // Register reset values.
   localparam logic [DIVISOR_WIDTH-1:0] CYCLES_PER_MM_RESET = 24'd470;
   localparam logic [AVG_WIDTH-1:0]     MAX_DISTANCE_RESET  = 12'd2000;

endpackage

/* design/epda_serial_div.sv */
module epda_serial_div
   import epda_pkg::*;
#(
   parameter int TIMESTAMP_WIDTH = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [TIMESTAMP_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]   divisor,
   output logic                       done,
   output logic [TIMESTAMP_WIDTH-1:0] quotient
);

   localparam int CNT_WIDTH = $clog2(TIMESTAMP_WIDTH + 1);

   logic [DIVISOR_WIDTH-1:0]   rem_ff, rem_in;
   logic [TIMESTAMP_WIDTH-1:0] quo_ff, quo_in;
   logic [CNT_WIDTH-1:0]       count_ff, count_in;
   logic                       done_ff, done_in;
   logic [DIVISOR_WIDTH:0]     shifted;
   logic [DIVISOR_WIDTH:0]     diff;
   logic                       fits;

   // One quotient bit per cycle: the dividend shifts out of the top of the
   // quotient register while quotient bits shift in at the bottom.
   always_comb begin
      shifted  = {rem_ff, quo_ff[TIMESTAMP_WIDTH-1]};
      fits     = shifted >= {1'b0, divisor};
      diff     = shifted - {1'b0, divisor};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = CNT_WIDTH'(TIMESTAMP_WIDTH);
      end else if (count_ff != '0) begin
         rem_in   = fits ? diff[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
         quo_in   = {quo_ff[TIMESTAMP_WIDTH-2:0], fits};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == CNT_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/epda_average.sv */
module epda_average
   import epda_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 update,
   input  logic [AVG_WIDTH-1:0] reading,
   output logic                 slot_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [AVG_WIDTH-1:0] avg
);

   logic [AVG_WIDTH-1:0]   avg_ff, avg_in;
   logic                   valid_ff, valid_in;
   logic [AVG_WIDTH+2:0]   sum;

   // 7*avg + reading, formed as 8*avg - avg + reading.
   always_comb begin
      sum      = {avg_ff, 3'b000} - {3'b000, avg_ff} + {3'b000, reading};
      avg_in   = avg_ff;
      valid_in = valid_ff && !rsp_tready;
      if (update) begin
         avg_in   = sum[AVG_WIDTH+2:3];
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         avg_ff   <= avg_in;
         valid_ff <= valid_in;
      end
   end

   // The average only changes when the output slot is free, so the
   // average register doubles as the output data register.
   assign slot_free  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign avg        = avg_ff;

endmodule

/* design/echo_pulse_distance_averager_unit.sv */
// Echo pulse distance averager.
// The request channel carries edge events of an ultrasonic echo line: tuser
// is the edge polarity (1 = falling) and tdata the capture timestamp. A
// rising edge stores its timestamp and leaves the block ready. A falling edge forms
// the elapsed count, divides it by cycles_per_millimetre in a bit-serial
// restoring divider (one quotient bit per cycle), and, if the divisor is
// nonzero and the reading does not exceed max_distance_mm, updates the
// running average and presents it on the response channel. No new edge is
// accepted until the division and its result step are through, so the block
// takes one falling edge at a time. A dropped reading returns the block to
// idle with no response. Configuration is written through csr_we, csr_index
// and csr_wdata while the block is idle; the user is bound to this, as the
// block itself does not enforce it.
// A pending response sits in an output register; the block keeps accepting
// rising edges and starts the next division while it waits, and holds a new
// average back, with its input stalled, until the receiver takes the
// previous transaction.
// Synchronous reset clears the stored rise timestamp and the average to zero
// and restores cycles_per_millimetre to 470 and max_distance_mm to 2000.
module echo_pulse_distance_averager_unit
   import epda_pkg::*;
#(
   parameter int TIMESTAMP_WIDTH = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // [TIMESTAMP_WIDTH-1:0] capture_time, zero padded to whole bytes
   input  logic [((TIMESTAMP_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   // [0] edge_falling
   input  logic                                     req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [11:0] distance_avg_mm, [15:12] zero
   output logic [RSP_WIDTH-1:0]                     rsp_tdata,
   input  logic                                     csr_we,
   input  logic                                     csr_index,
   input  logic [CSR_WIDTH-1:0]                     csr_wdata
);

   localparam int CMP_WIDTH = (TIMESTAMP_WIDTH > AVG_WIDTH) ? TIMESTAMP_WIDTH : AVG_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   state_type                  state_ff, state_in;
   logic [TIMESTAMP_WIDTH-1:0] rise_ff, rise_in;
   logic [DIVISOR_WIDTH-1:0]   cpm_ff;
   logic [AVG_WIDTH-1:0]       max_ff;

   logic [TIMESTAMP_WIDTH-1:0] capture;
   logic [TIMESTAMP_WIDTH-1:0] elapsed;
   logic                       wrap;
   logic                       accept;
   logic                       start;
   logic                       div_done;
   logic [TIMESTAMP_WIDTH-1:0] quotient;
   logic [CMP_WIDTH-1:0]       quo_ext;
   logic                       drop;
   logic                       update;
   logic                       slot_free;
   logic [AVG_WIDTH-1:0]       avg;

   assign capture    = req_tdata[TIMESTAMP_WIDTH-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && req_tuser;

   // When the fall is not after the rise, the count is all ones minus
   // (rise - fall), which is fall - rise - 1 modulo the timer range.
   assign wrap    = (capture <= rise_ff);
   assign elapsed = capture - rise_ff - {{(TIMESTAMP_WIDTH-1){1'b0}}, wrap};

   assign quo_ext = CMP_WIDTH'(quotient);
   assign drop    = (cpm_ff == '0) || (quo_ext > CMP_WIDTH'(max_ff));
   assign update  = (state_ff == ST_RESULT) && !drop && slot_free;

   always_comb begin
      state_in = state_ff;
      rise_in  = rise_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_tuser) begin
               rise_in = capture;
            end
            if (start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (drop || slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rise_ff  <= '0;
         cpm_ff   <= CYCLES_PER_MM_RESET;
         max_ff   <= MAX_DISTANCE_RESET;
      end else begin
         state_ff <= state_in;
         rise_ff  <= rise_in;
         if (csr_we && csr_index == CSR_CYCLES_PER_MM) begin
            cpm_ff <= csr_wdata[DIVISOR_WIDTH-1:0];
         end
         if (csr_we && csr_index == CSR_MAX_DISTANCE) begin
            max_ff <= csr_wdata[AVG_WIDTH-1:0];
         end
      end
   end

   epda_serial_div #(
      .TIMESTAMP_WIDTH(TIMESTAMP_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (elapsed),
      .divisor  (cpm_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   epda_average u_avg (
      .clock      (clock),
      .reset      (reset),
      .update     (update),
      .reading    (quo_ext[AVG_WIDTH-1:0]),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .avg        (avg)
   );

   assign rsp_tdata = {{(RSP_WIDTH-AVG_WIDTH){1'b0}}, avg};

endmodule
